>>> sv/abcull_pkg.sv
// Shared widths, register indexes and reset values for the clip-space box culler.
// Used by aabb_clip_space_cull and abcull_checker; depends on nothing else.
package abcull_pkg;

  localparam int unsigned CoordW = 16;  // Q12.4 box coordinate
  localparam int unsigned CoefW  = 16;  // Q4.12 matrix coefficient
  localparam int unsigned RowW   = 4 * CoefW;
  localparam int unsigned ProdW  = CoordW + CoefW;  // Q16.16 product
  localparam int unsigned WTermW = CoefW + 4;       // coefficient times 16 (w = 1.0)
  localparam int unsigned PairW  = ProdW + 1;       // sum of two products
  localparam int unsigned SumW   = ProdW + 2;       // full four-term dot product
  localparam int unsigned CmpW   = SumW + 1;        // clip value against +/- w
  localparam int unsigned CodeW  = 6;

  localparam int unsigned NumRows    = 4;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned NumCorners = 8;
  localparam int unsigned WRow       = 3;  // row index of clip w

  localparam logic [CodeW-1:0] OcAll = 6'b111111;

  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowX = 8'd0,
    CfgRowY = 8'd1,
    CfgRowZ = 8'd2,
    CfgRowW = 8'd3
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [RowW-1:0]          row_t;

  // Identity matrix
  localparam row_t RowReset [NumRows] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

endpackage

>>> sv/aabb_clip_space_cull.sv
// Clip-space culler for axis-aligned boxes: eight corners through a 4x4 matrix,
// outcodes against +/- w, AND across corners. Depends on abcull_pkg.
//
// Usage:
//   Configuration: write rows x, y, z, w of the matrix (index 0..3) through
//   cfg_valid_i / cfg_data_i while no box is in flight; cfg_ready_o is always
//   high and indexes above three are dropped. Reset loads the identity matrix
//   and empties the pipeline.
//   Input: one box per transfer on in_valid_i / in_ready_o.
//   Output: visible_o and shared_outcode_o per transfer on out_valid_o /
//   out_ready_i, in input order.
//   Pipeline: four register stages (products, pair sums, corner sums,
//   outcodes ANDed into the output register). A result is offered from the
//   output register; one box per cycle is sustained while out_ready_i stays
//   high. The product stage holds 24 16x16 multipliers plus the four w terms.
//   A stall on out_ready_i holds the output and backs up stage by stage;
//   in_ready_o drops only once every stage holds a box.
module aabb_clip_space_cull (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [abcull_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [abcull_pkg::RowW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  abcull_pkg::coord_t           box_min_x_i,
  input  abcull_pkg::coord_t           box_min_y_i,
  input  abcull_pkg::coord_t           box_min_z_i,
  input  abcull_pkg::coord_t           box_max_x_i,
  input  abcull_pkg::coord_t           box_max_y_i,
  input  abcull_pkg::coord_t           box_max_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         visible_o,
  output logic [abcull_pkg::CodeW-1:0] shared_outcode_o
);
  import abcull_pkg::*;

  row_t row_q [NumRows];

  logic en_s1, en_s2, en_s3, en_s4;
  logic v1_q, v2_q, v3_q, v4_q;

  coord_t                    coord [NumAxes][2];
  logic signed [ProdW-1:0]   prod_d  [NumRows][NumAxes][2];
  logic signed [ProdW-1:0]   prod_q  [NumRows][NumAxes][2];
  logic signed [WTermW-1:0]  wterm_d [NumRows];
  logic signed [WTermW-1:0]  wterm_q [NumRows];
  logic signed [PairW-1:0]   pxy_d   [NumRows][4];
  logic signed [PairW-1:0]   pxy_q   [NumRows][4];
  logic signed [PairW-1:0]   pzw_d   [NumRows][2];
  logic signed [PairW-1:0]   pzw_q   [NumRows][2];
  logic signed [SumW-1:0]    corner_d [NumRows][NumCorners];
  logic signed [SumW-1:0]    corner_q [NumRows][NumCorners];
  logic [CodeW-1:0]          shared_d, shared_q;

  // Configuration rows
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) row_q[r] <= RowReset[r];
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRowX: row_q[0] <= cfg_data_i;
        CfgRowY: row_q[1] <= cfg_data_i;
        CfgRowZ: row_q[2] <= cfg_data_i;
        CfgRowW: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage advances when empty or when the next one moves
  assign en_s4      = !v4_q || out_ready_i;
  assign en_s3      = !v3_q || en_s4;
  assign en_s2      = !v2_q || en_s3;
  assign en_s1      = !v1_q || en_s2;
  assign in_ready_o = en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en_s1) v1_q <= in_valid_i;
      if (en_s2) v2_q <= v1_q;
      if (en_s3) v3_q <= v2_q;
      if (en_s4) v4_q <= v3_q;
    end
  end

  // Stage 1: every coefficient times both extremes of its axis
  always_comb begin
    coord[0][0] = box_min_x_i;
    coord[0][1] = box_max_x_i;
    coord[1][0] = box_min_y_i;
    coord[1][1] = box_max_y_i;
    coord[2][0] = box_min_z_i;
    coord[2][1] = box_max_z_i;
    for (int r = 0; r < NumRows; r++) begin
      for (int a = 0; a < NumAxes; a++) begin
        for (int s = 0; s < 2; s++) begin
          prod_d[r][a][s] = ProdW'($signed(row_q[r][CoefW*a +: CoefW])) *
                            ProdW'(coord[a][s]);
        end
      end
      wterm_d[r] = $signed({row_q[r][CoefW*WRow +: CoefW], 4'b0000});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      prod_q  <= prod_d;
      wterm_q <= wterm_d;
    end
  end

  // Stage 2: x+y for the four xy pairs, z+w for both z extremes
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          pxy_d[r][2*j+i] = PairW'(prod_q[r][0][i]) + PairW'(prod_q[r][1][j]);
        end
      end
      for (int k = 0; k < 2; k++) begin
        pzw_d[r][k] = PairW'(prod_q[r][2][k]) + PairW'(wterm_q[r]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s2) begin
      pxy_q <= pxy_d;
      pzw_q <= pzw_d;
    end
  end

  // Stage 3: full clip coordinate of each corner; corner bits are {z, y, x}
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int n = 0; n < NumCorners; n++) begin
        corner_d[r][n] = SumW'(pxy_q[r][n[1:0]]) + SumW'(pzw_q[r][n[2]]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s3) corner_q <= corner_d;
  end

  // Stage 4: outcodes and their AND. c < -w is c + w < 0; c > w is w - c < 0.
  always_comb begin
    logic signed [CmpW-1:0] lo_sum;
    logic signed [CmpW-1:0] hi_diff;
    logic [CodeW-1:0]       code;
    shared_d = OcAll;
    lo_sum   = '0;
    hi_diff  = '0;
    code     = '0;
    for (int n = 0; n < NumCorners; n++) begin
      for (int a = 0; a < NumAxes; a++) begin
        lo_sum      = CmpW'(corner_q[a][n]) + CmpW'(corner_q[WRow][n]);
        hi_diff     = CmpW'(corner_q[WRow][n]) - CmpW'(corner_q[a][n]);
        code[2*a]   = lo_sum[CmpW-1];
        code[2*a+1] = hi_diff[CmpW-1];
      end
      shared_d = shared_d & code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s4) shared_q <= shared_d;
  end

  assign out_valid_o      = v4_q;
  assign shared_outcode_o = shared_q;
  assign visible_o        = (shared_q == '0);

endmodule

>>> sv/abcull_checker.sv
// Port-level checks for aabb_clip_space_cull, attached by the bind at the end.
// Depends on abcull_pkg.
module abcull_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           visible_o,
  input logic [abcull_pkg::CodeW-1:0]   shared_outcode_o
);
  import abcull_pkg::*;

  logic in_xfer, out_xfer;
  logic [2:0] inflight_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Count boxes taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(visible_o) && $stable(shared_outcode_o))
    else $error("result changed or dropped while stalled");

  a_visible_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visible_o == (shared_outcode_o == '0)))
    else $error("visible flag disagrees with shared outcode");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != 3'd0))
    else $error("result offered with no box in flight");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && inflight_q == 3'd4))
    else $error("input stalled while pipeline not full and blocked");

  // Configuration port is always ready
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind aabb_clip_space_cull abcull_checker u_abcull_checker (.*);

>>> tb/tb_aabb_clip_space_cull.sv
`timescale 1ns / 1ps
// Testbench for aabb_clip_space_cull: random boxes under several matrices, checked against
// an in-bench outcode predictor. Depends on abcull_pkg and the culler RTL.
module tb_aabb_clip_space_cull;
  import abcull_pkg::*;

  localparam logic [CodeW-1:0] OcLeft   = 6'b000001;
  localparam logic [CodeW-1:0] OcRight  = 6'b000010;
  localparam logic [CodeW-1:0] OcTop    = 6'b000100;
  localparam logic [CodeW-1:0] OcBottom = 6'b001000;
  localparam logic [CodeW-1:0] OcNear   = 6'b010000;
  localparam logic [CodeW-1:0] OcFar    = 6'b100000;

  localparam logic [CoefW-1:0]   CoefOne     = 16'h1000;  // 1.0 in Q4.12
  localparam longint             WOne        = 16;        // 1.0 in Q12.4
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxLast  = 8'hFF;

  localparam int WatchdogLimit = 2000;
  localparam int RandPhases    = 8;
  localparam int BoxesPerPhase = 175;
  localparam int TailCycles    = 8;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic             visible;
    logic [CodeW-1:0] code;
  } cull_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RowW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  coord_t             box_min_x_i = '0;
  coord_t             box_min_y_i = '0;
  coord_t             box_min_z_i = '0;
  coord_t             box_max_x_i = '0;
  coord_t             box_max_y_i = '0;
  coord_t             box_max_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               visible_o;
  logic [CodeW-1:0]   shared_outcode_o;

  aabb_clip_space_cull dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .box_min_x_i      (box_min_x_i),
    .box_min_y_i      (box_min_y_i),
    .box_min_z_i      (box_min_z_i),
    .box_max_x_i      (box_max_x_i),
    .box_max_y_i      (box_max_y_i),
    .box_max_z_i      (box_max_z_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .visible_o        (visible_o),
    .shared_outcode_o (shared_outcode_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  row_t         mvp_rows [NumRows];
  box_t         box_pending [$];
  cull_result_t cull_expected [$];
  box_t         box_next;
  bit           box_held;
  bit           out_taken;
  int           in_gap;
  int           in_calm;
  int           out_stall;
  int           out_calm;
  int           idle_cycles;
  int           mismatch_count;

  // Transform all eight corners and AND their outcodes.
  function automatic cull_result_t predict_cull(box_t b);
    longint           xs [2];
    longint           ys [2];
    longint           zs [2];
    longint           vals [4];
    longint           clip [4];
    logic signed [CoefW-1:0] cf;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] shared;
    cull_result_t     res;
    xs[0] = $signed(b.min_x);
    ys[0] = $signed(b.min_y);
    zs[0] = $signed(b.min_z);
    xs[1] = $signed(b.max_x);
    ys[1] = $signed(b.max_y);
    zs[1] = $signed(b.max_z);
    shared = OcAll;
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          vals[0] = xs[i];
          vals[1] = ys[j];
          vals[2] = zs[k];
          vals[3] = WOne;
          for (int r = 0; r < NumRows; r++) begin
            clip[r] = 0;
            for (int c = 0; c < 4; c++) begin
              cf = mvp_rows[r][16*c +: 16];
              clip[r] += longint'(cf) * vals[c];
            end
          end
          code = '0;
          if (clip[0] < -clip[WRow]) code |= OcLeft;
          if (clip[0] > clip[WRow])  code |= OcRight;
          if (clip[1] < -clip[WRow]) code |= OcTop;
          if (clip[1] > clip[WRow])  code |= OcBottom;
          if (clip[2] < -clip[WRow]) code |= OcNear;
          if (clip[2] > clip[WRow])  code |= OcFar;
          shared &= code;
        end
      end
    end
    res.visible = (shared == '0);
    res.code    = shared;
    return res;
  endfunction

  function automatic box_t mk_box(int ax, int ay, int az, int bx, int by, int bz);
    box_t b;
    b.min_x = ax[15:0];
    b.min_y = ay[15:0];
    b.min_z = az[15:0];
    b.max_x = bx[15:0];
    b.max_y = by[15:0];
    b.max_z = bz[15:0];
    return b;
  endfunction

  // Mostly small boxes near the frustum, some fully random, swapped or flat.
  function automatic box_t rand_box();
    box_t b;
    int   kind;
    int   span;
    int   lo [3];
    int   ext [3];
    int   mn [3];
    int   mx [3];
    kind = $urandom_range(0, 9);
    if (kind == 6 || kind == 7) begin
      b = {$urandom, $urandom, $urandom};
      return b;
    end
    span = 1 << $urandom_range(4, 14);
    for (int a = 0; a < 3; a++) begin
      lo[a]  = $urandom_range(0, 2 * span) - span;
      ext[a] = (kind == 9 && $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, span);
      mn[a]  = (kind == 8) ? lo[a] + ext[a] : lo[a];
      mx[a]  = (kind == 8) ? lo[a] : lo[a] + ext[a];
    end
    b.min_x = mn[0][15:0];
    b.min_y = mn[1][15:0];
    b.min_z = mn[2][15:0];
    b.max_x = mx[0][15:0];
    b.max_y = mx[1][15:0];
    b.max_z = mx[2][15:0];
    return b;
  endfunction

  // Near-diagonal row: strong term on its own axis, small cross terms.
  function automatic row_t frustum_row(int axis);
    row_t r;
    int   cf;
    for (int c = 0; c < 4; c++) begin
      if (c == axis) cf = $urandom_range(1024, 12288);
      else cf = $urandom_range(0, 1024) - 512;
      if (c == axis && $urandom_range(0, 7) == 0) cf = -cf;
      r[16*c +: 16] = cf[15:0];
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, with calm stretches of no gaps.
  function automatic int draw_gap(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 80);
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic write_row(logic [CfgIdxW-1:0] idx, row_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgRowX: mvp_rows[0] = data;
      CfgRowY: mvp_rows[1] = data;
      CfgRowZ: mvp_rows[2] = data;
      CfgRowW: mvp_rows[3] = data;
      default: ;  // out-of-range index: drop
    endcase
  endtask

  task automatic load_matrix(row_t rx, row_t ry, row_t rz, row_t rw);
    write_row(CfgRowX, rx);
    write_row(CfgRowY, ry);
    write_row(CfgRowZ, rz);
    write_row(CfgRowW, rw);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (box_pending.size() != 0 || box_held || cull_expected.size() != 0)
      @(negedge clk_i);
  endtask

  // Box side: predict at the transfer, present the next box at the falling edge.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cull_expected.push_back(predict_cull({box_min_x_i, box_min_y_i, box_min_z_i,
                                            box_max_x_i, box_max_y_i, box_max_z_i}));
      box_held = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !box_held) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (box_pending.size() != 0) begin
        box_next = box_pending.pop_front();
        box_min_x_i <= box_next.min_x;
        box_min_y_i <= box_next.min_y;
        box_min_z_i <= box_next.min_z;
        box_max_x_i <= box_next.max_x;
        box_max_y_i <= box_next.max_y;
        box_max_z_i <= box_next.max_z;
        box_held = 1'b1;
        in_gap = draw_gap(in_calm);
      end
    end
    in_valid_i <= box_held;
  end

  // Result side: compare each transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      if (cull_expected.size() == 0) begin
        $display("%0t: result with no box outstanding, visible %0b code %02h",
                 $time, visible_o, shared_outcode_o);
        mismatch_count++;
      end else begin
        if (visible_o !== cull_expected[0].visible) begin
          $display("%0t: visible mismatch, expected %0b, actual %0b",
                   $time, cull_expected[0].visible, visible_o);
          mismatch_count++;
        end
        if (shared_outcode_o !== cull_expected[0].code) begin
          $display("%0t: shared_outcode mismatch, expected %02h, actual %02h",
                   $time, cull_expected[0].code, shared_outcode_o);
          mismatch_count++;
        end
        void'(cull_expected.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_taken) begin
      out_stall = draw_gap(out_calm);
      out_taken = 1'b0;
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int r = 0; r < NumRows; r++) begin
      mvp_rows[r] = '0;
      mvp_rows[r][16*r +: 16] = CoefOne;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Identity after reset: extremes, each plane alone, boundary, swapped, flat.
    box_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
    box_pending.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    box_pending.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    box_pending.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    box_pending.push_back(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    box_pending.push_back(mk_box(-40, -8, -8, -17, 8, 8));
    box_pending.push_back(mk_box(-16, -8, -8, -16, 8, 8));
    box_pending.push_back(mk_box(17, -8, -8, 40, 8, 8));
    box_pending.push_back(mk_box(-8, -40, -8, 8, -17, 8));
    box_pending.push_back(mk_box(-8, 17, -8, 8, 40, 8));
    box_pending.push_back(mk_box(-8, -8, -40, 8, 8, -17));
    box_pending.push_back(mk_box(-8, -8, 17, 8, 8, 40));
    box_pending.push_back(mk_box(-100, -100, -8, -17, -17, 8));
    box_pending.push_back(mk_box(5, 5, 5, 5, 5, 5));
    wait_idle();

    // Extreme matrices
    load_matrix('0, '0, '0, '0);
    box_pending.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    box_pending.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    wait_idle();
    load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    box_pending.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    box_pending.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    wait_idle();
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    box_pending.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    box_pending.push_back(mk_box(0, 0, 0, 1, 1, 1));
    wait_idle();
    load_matrix({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}});
    box_pending.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    wait_idle();

    // Negative w: compare literally against cw and -cw
    load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'hF000_0000_0000_0000);
    box_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
    box_pending.push_back(mk_box(32767, -32768, 0, 32767, 32767, 0));
    wait_idle();

    // Writes beyond row w are dropped; the identity must still hold
    load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
    write_row(CfgIdxSpare, {64{1'b1}});
    write_row(CfgIdxLast, {64{1'b1}});
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    box_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < RandPhases; p++) begin
      if (p % 4 == 0) begin
        load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      end else if (p == 3) begin
        // partial update: keep z and w rows
        write_row(CfgRowX, frustum_row(0));
        write_row(CfgRowY, frustum_row(1));
        write_row(CfgIdxSpare, {$urandom, $urandom});
        @(negedge clk_i) cfg_valid_i <= 1'b0;
      end else begin
        load_matrix(frustum_row(0), frustum_row(1), frustum_row(2), frustum_row(3));
      end
      for (int n = 0; n < BoxesPerPhase; n++) box_pending.push_back(rand_box());
      wait_idle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && cull_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/abcull_pkg.sv
sv/aabb_clip_space_cull.sv
sv/abcull_checker.sv
tb/tb_aabb_clip_space_cull.sv
